### hw/rtl/dbcs_pkg.sv
`default_nettype none

package dbcs_pkg;

    // Default table depth and fixed codes
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam logic [7:0] THRESH_RESET = 8'hD1;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_TEXT    = 1'b0;
    localparam logic REQ_PRELOAD = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPEND,
        ST_EMIT
    } state_t;

    // How the pending result register is loaded
    typedef enum logic [2:0] {
        RES_NONE,
        RES_EOT,
        RES_ECHO,
        RES_HIT,
        RES_APPEND
    } res_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    take_lead;
        logic    clear_await;
        logic    latch_text;
        logic    latch_preload;
        logic    search_start;
        logic    search_issue;
        res_op_t res_op;
        logic    out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic preload;
        logic byte_zero;
        logic byte_newline;
        logic awaiting;
        logic lead_ok;
        logic count_zero;
        logic hit;
        logic miss_end;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/dbcs_ctrl.sv
`default_nettype none

module dbcs_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  dbcs_pkg::dp_status_t    status,
    output dbcs_pkg::ctrl_cmd_t     cmd
);
    import dbcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_op = RES_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (status.preload)
                    begin
                        if (status.byte_zero)
                        begin
                            cmd.res_op = RES_ECHO;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cmd.latch_preload = 1'b1;
                            state_next        = ST_APPEND;
                        end
                    end
                    else if (!status.awaiting)
                    begin
                        // lead position
                        if (status.byte_zero)
                        begin
                            cmd.res_op = RES_EOT;
                            state_next = ST_EMIT;
                        end
                        else if (!status.byte_newline)
                        begin
                            cmd.take_lead = 1'b1;
                        end
                    end
                    else
                    begin
                        // trail position
                        cmd.clear_await = 1'b1;
                        if (status.byte_zero)
                        begin
                            cmd.res_op = RES_EOT;
                            state_next = ST_EMIT;
                        end
                        else if (status.lead_ok)
                        begin
                            cmd.latch_text = 1'b1;
                            if (status.count_zero)
                            begin
                                state_next = ST_APPEND;
                            end
                            else
                            begin
                                cmd.search_start = 1'b1;
                                state_next       = ST_SEARCH;
                            end
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_issue = 1'b1;
                if (status.hit)
                begin
                    cmd.res_op = RES_HIT;
                    state_next = ST_EMIT;
                end
                else if (status.miss_end)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.res_op = RES_APPEND;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/dbcs_datapath.sv
`default_nettype none

module dbcs_datapath #(
    parameter int TABLE_ENTRIES = dbcs_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire  [7:0]              cfg_wdata,
    input  wire                     in_type,
    input  wire  [7:0]              in_byte,
    input  wire  [7:0]              in_trail,
    input  dbcs_pkg::ctrl_cmd_t     cmd,
    output dbcs_pkg::dp_status_t    status,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [31:0]             m_data,
    output logic                    m_last
);
    import dbcs_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    // Code table
    logic [15:0] mem [TABLE_ENTRIES];

    logic [7:0]        thr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              await_reg;
    logic [7:0]        held_reg;
    logic [15:0]       code_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [15:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;

    logic [7:0]        res_lead_reg;
    logic [7:0]        res_trail_reg;
    logic              res_added_reg;
    logic              res_full_reg;
    logic [7:0]        res_count_reg;
    logic              res_eot_reg;

    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_last_reg;

    logic              full;
    logic              issue;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign issue = cmd.search_issue && (idx_reg < count_reg);
    assign count_next = full ? count_reg : count_reg + CNT_W'(1);

    // Status toward the controller
    always_comb
    begin
        status.preload      = (in_type == REQ_PRELOAD);
        status.byte_zero    = (in_byte == 8'd0);
        status.byte_newline = (in_byte == NEWLINE_CODE);
        status.awaiting     = await_reg;
        status.lead_ok      = (held_reg >= thr_reg);
        status.count_zero   = (count_reg == '0);
        status.hit          = rd_valid_reg && (rd_data_reg == code_reg);
        status.miss_end     = rd_valid_reg && rd_last_reg && (rd_data_reg != code_reg);
        status.out_free     = !m_valid_reg || m_ready;
    end

    // Control state: threshold, pairing, fill count, read pipeline valid, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESH_RESET;
            count_reg    <= '0;
            await_reg    <= 1'b0;
            held_reg     <= 8'd0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.take_lead)
            begin
                held_reg  <= in_byte;
                await_reg <= 1'b1;
            end
            else if (cmd.clear_await)
            begin
                await_reg <= 1'b0;
            end
            if (cmd.res_op == RES_APPEND)
            begin
                count_reg <= count_next;
            end
            if (cmd.search_start)
            begin
                rd_valid_reg <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= issue;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search address, table access and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_text)
        begin
            code_reg <= {held_reg, in_byte};
        end
        else if (cmd.latch_preload)
        begin
            code_reg <= {in_byte, in_trail};
        end

        if (cmd.search_start)
        begin
            idx_reg <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end

        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
            rd_last_reg <= ((idx_reg + CNT_W'(1)) == count_reg);
        end

        if ((cmd.res_op == RES_APPEND) && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= code_reg;
        end

        case (cmd.res_op)
            RES_EOT:
            begin
                res_lead_reg  <= 8'd0;
                res_trail_reg <= 8'd0;
                res_added_reg <= 1'b0;
                res_full_reg  <= 1'b0;
                res_count_reg <= 8'(count_reg);
                res_eot_reg   <= 1'b1;
            end
            RES_ECHO:
            begin
                res_lead_reg  <= in_byte;
                res_trail_reg <= in_trail;
                res_added_reg <= 1'b0;
                res_full_reg  <= 1'b0;
                res_count_reg <= 8'(count_reg);
                res_eot_reg   <= 1'b0;
            end
            RES_HIT:
            begin
                res_lead_reg  <= code_reg[15:8];
                res_trail_reg <= code_reg[7:0];
                res_added_reg <= 1'b0;
                res_full_reg  <= 1'b0;
                res_count_reg <= 8'(count_reg);
                res_eot_reg   <= 1'b0;
            end
            RES_APPEND:
            begin
                res_lead_reg  <= code_reg[15:8];
                res_trail_reg <= code_reg[7:0];
                res_added_reg <= !full;
                res_full_reg  <= full;
                res_count_reg <= 8'(count_next);
                res_eot_reg   <= 1'b0;
            end
            default:
            begin
            end
        endcase

        // Output register
        if (cmd.out_load)
        begin
            m_data_reg <= {6'd0, res_count_reg, res_full_reg, res_added_reg,
                           res_trail_reg, res_lead_reg};
            m_last_reg <= res_eot_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

### hw/rtl/double_byte_code_set_collector_core.sv
// A lead byte, newline or ignored pair gives no result and leaves the block idle.
// A nonzero-lead preload goes through the append and emit states, a zero-lead preload or
// end-of-text item straight to emit; a collected pair is first searched one entry per cycle,
// then appended on a miss. A new item is taken only after the result enters the output register.
// Reset (rst_n low, async) empties the table count, clears pairing state and
// restores lead_threshold to 0xD1; table contents are not cleared.
`default_nettype none

module double_byte_code_set_collector_core #(
    parameter int TABLE_ENTRIES = dbcs_pkg::TABLE_ENTRIES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,     // lead_threshold
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // [7:0] byte_value, [15:8] trail_value
    input  wire         s_axis_tuser,  // [0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] lead_byte, [15:8] trail_byte,
                                       // [16] newly_added, [17] table_full,
                                       // [25:18] entry_count, [31:26] zero
    output logic        m_axis_tlast   // end_of_text
);
    import dbcs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    dbcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, search pipeline and output register
    dbcs_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_type   (s_axis_tuser),
        .in_byte   (s_axis_tdata[7:0]),
        .in_trail  (s_axis_tdata[15:8]),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dbcs_pkg::*;

    localparam int TBL_DEPTH    = TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 80;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD    = 300;

    // One result as it leaves the block
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic       added;
        logic       full;
        logic [7:0] count;
        logic       eot;
    } code_report_t;

    // One row of the directed part; want is only used when typed is set
    typedef struct packed {
        logic         kind;
        logic [7:0]   bval;
        logic [7:0]   tval;
        logic         typed;
        code_report_t want;
    } stim_row_t;

    localparam code_report_t NO_REPORT = '0;
    localparam int DIR_N = 25;

    // Directed rows, run with the reset threshold (0xD1) on an empty table
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        // end of text on an empty table
        '{REQ_TEXT,    8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 1'b1}},
        // newline as lead is skipped
        '{REQ_TEXT,    8'h0A, 8'hFF, 1'b0, NO_REPORT},
        // lead just below threshold: pair dropped
        '{REQ_TEXT,    8'hD0, 8'hFF, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h41, 8'h00, 1'b0, NO_REPORT},
        // lead at threshold: first entry
        '{REQ_TEXT,    8'hD1, 8'h00, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h01, 8'h00, 1'b1, '{8'hD1, 8'h01, 1'b1, 1'b0, 8'd1, 1'b0}},
        // same pair again: hit
        '{REQ_TEXT,    8'hD1, 8'hFF, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h01, 8'hFF, 1'b0, NO_REPORT},
        // top code
        '{REQ_TEXT,    8'hFF, 8'h00, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'hFF, 8'h00, 1'b1, '{8'hFF, 8'hFF, 1'b1, 1'b0, 8'd2, 1'b0}},
        // zero trail ends the text, pair dropped
        '{REQ_TEXT,    8'hFF, 8'hFF, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h00, 8'hFF, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 8'd2, 1'b1}},
        // preload with zero lead is echoed but not stored
        '{REQ_PRELOAD, 8'h00, 8'hAB, 1'b1, '{8'h00, 8'hAB, 1'b0, 1'b0, 8'd2, 1'b0}},
        // preloads append without a search
        '{REQ_PRELOAD, 8'hFF, 8'hFF, 1'b0, NO_REPORT},
        '{REQ_PRELOAD, 8'h80, 8'h7F, 1'b0, NO_REPORT},
        // newline in trail position is an ordinary trail
        '{REQ_TEXT,    8'hE0, 8'h00, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h0A, 8'h00, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'hFF, 8'h55, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'hFF, 8'hAA, 1'b0, NO_REPORT},
        // trail_value on text must be ignored
        '{REQ_TEXT,    8'hD5, 8'hFF, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h55, 8'hAA, 1'b0, NO_REPORT},
        // preload between lead and trail leaves the pairing alone
        '{REQ_TEXT,    8'hE1, 8'h00, 1'b0, NO_REPORT},
        '{REQ_PRELOAD, 8'h90, 8'h12, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h34, 8'h00, 1'b0, NO_REPORT},
        '{REQ_TEXT,    8'h00, 8'h00, 1'b0, NO_REPORT}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Shadow of the collector state
    logic [15:0] code_tbl [TBL_DEPTH];
    int          code_cnt;
    bit          await_trail;
    logic [7:0]  held_lead;
    logic [7:0]  lead_thresh;

    code_report_t code_reports_q [$];
    int          errors;
    int          sent_items;
    int          rx_count;
    int          stall_cycles;
    bit          no_idle;

    double_byte_code_set_collector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Predict what one accepted item does to the code set
    task automatic collect_code(input logic kind, input logic [7:0] bval,
                                input logic [7:0] tval, output bit has,
                                output code_report_t rep);
        bit hit;
        has = 1'b0;
        hit = 1'b0;
        rep = '0;
        if (kind == REQ_PRELOAD)
        begin
            has = 1'b1;
            rep.lead  = bval;
            rep.trail = tval;
            if (bval != 8'h00)
            begin
                if (code_cnt < TBL_DEPTH)
                begin
                    code_tbl[code_cnt] = {bval, tval};
                    code_cnt++;
                    rep.added = 1'b1;
                end
                else
                    rep.full = 1'b1;
            end
        end
        else if (!await_trail)
        begin
            if (bval == 8'h00)
            begin
                has = 1'b1;
                rep.eot = 1'b1;
            end
            else if (bval != NEWLINE_CODE)
            begin
                held_lead   = bval;
                await_trail = 1'b1;
            end
        end
        else
        begin
            await_trail = 1'b0;
            if (bval == 8'h00)
            begin
                has = 1'b1;
                rep.eot = 1'b1;
            end
            else if (held_lead >= lead_thresh)
            begin
                has = 1'b1;
                rep.lead  = held_lead;
                rep.trail = bval;
                for (int i = 0; i < code_cnt; i++)
                    if (code_tbl[i] == {held_lead, bval})
                        hit = 1'b1;
                if (!hit)
                begin
                    if (code_cnt < TBL_DEPTH)
                    begin
                        code_tbl[code_cnt] = {held_lead, bval};
                        code_cnt++;
                        rep.added = 1'b1;
                    end
                    else
                        rep.full = 1'b1;
                end
            end
        end
        rep.count = code_cnt[7:0];
    endtask

    // Offer one item after a random gap; returns at the next falling edge
    task automatic send_item(input logic kind, input logic [7:0] bval,
                             input logic [7:0] tval, input logic typed = 1'b0,
                             input code_report_t want = '0);
        int gap;
        bit has;
        code_report_t pred;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tval, bval};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
        collect_code(kind, bval, tval, has, pred);
        if (has)
            code_reports_q.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Mostly well-formed pairs, plus preloads, newlines, text ends and noise
    task automatic send_random_event();
        int pick;
        int k;
        logic [7:0] ld;
        logic [7:0] tr;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            if (code_cnt > 0 && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, code_cnt - 1);
                {ld, tr} = code_tbl[k];
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                    ld = 8'($urandom_range(lead_thresh, 255));
                else
                    ld = 8'($urandom_range(1, 255));
                tr = 8'($urandom_range(1, 255));
            end
            send_item(REQ_TEXT, ld, 8'($urandom));
            send_item(REQ_TEXT, tr, 8'($urandom));
        end
        else if (pick < 75)
        begin
            ld = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
            send_item(REQ_PRELOAD, ld, 8'($urandom));
        end
        else if (pick < 83)
            send_item(REQ_TEXT, NEWLINE_CODE, 8'($urandom));
        else if (pick < 88)
            send_item(REQ_TEXT, 8'h00, 8'($urandom));
        else
            send_item(REQ_TEXT, 8'($urandom), 8'($urandom));
    endtask

    // Drop valid and wait for every pending result, then let the block go idle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (code_reports_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lead_thresh = value;
        @(negedge clk);
    endtask

    // Main sequence
    initial
    begin : stimulus
        logic [7:0] phase_thresh [5];
        int start_items;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = THRESH_RESET;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_TEXT;
        code_cnt      = 0;
        await_trail   = 1'b0;
        held_lead     = 8'h00;
        lead_thresh   = THRESH_RESET;
        errors        = 0;
        sent_items    = 0;
        no_idle       = 1'b0;
        phase_thresh  = '{8'h00, 8'hC0, 8'hFF, 8'($urandom_range(1, 254)), 8'h00};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows
        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_ROWS[i].kind, DIR_ROWS[i].bval, DIR_ROWS[i].tval,
                      DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // random phases, each under its own threshold and ended by a text end
        for (int p = 0; p < 5; p++)
        begin
            drain_and_settle();
            write_threshold(phase_thresh[p]);
            no_idle = (p == 2);
            start_items = sent_items;
            while (sent_items - start_items < PHASE_ITEMS)
                send_random_event();
            send_item(REQ_TEXT, 8'h00, 8'($urandom));
        end
        no_idle = 1'b0;

        drain_and_settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[double_byte_code_set_collector_core] OK");
        else
            $display("[double_byte_code_set_collector_core] ERROR");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off
    initial
    begin : drain_results
        int gap;
        bit held_once;
        held_once     = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!held_once && rx_count >= 20)
            begin
                gap = LONG_HOLD;
                held_once = 1'b1;
            end
            else
                gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest prediction
    initial rx_count = 0;

    always @(posedge clk)
    begin : check_reports
        code_report_t got;
        code_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_count++;
            got.lead  = m_axis_tdata[7:0];
            got.trail = m_axis_tdata[15:8];
            got.added = m_axis_tdata[16];
            got.full  = m_axis_tdata[17];
            got.count = m_axis_tdata[25:18];
            got.eot   = m_axis_tlast;
            if (code_reports_q.size() == 0)
            begin
                $error("unexpected result transfer: tdata %08h tlast %0b",
                       m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = code_reports_q.pop_front();
                if (got.lead !== want.lead)
                begin
                    $error("lead_byte: expected %02h, got %02h", want.lead, got.lead);
                    errors++;
                end
                if (got.trail !== want.trail)
                begin
                    $error("trail_byte: expected %02h, got %02h", want.trail, got.trail);
                    errors++;
                end
                if (got.added !== want.added)
                begin
                    $error("newly_added: expected %0b, got %0b", want.added, got.added);
                    errors++;
                end
                if (got.full !== want.full)
                begin
                    $error("table_full: expected %0b, got %0b", want.full, got.full);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
                if (got.eot !== want.eot)
                begin
                    $error("end_of_text: expected %0b, got %0b", want.eot, got.eot);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    initial stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[double_byte_code_set_collector_core] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
